// ===== sv/hfcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfcc_pkg
// Opcodes, binary16 field masks, result bundle and bit-level compare helpers
// for the half float compare and classify unit.
// ----------------------------------------------------------------------------
package hfcc_pkg;

  localparam int unsigned OP_W   = 5;
  localparam int unsigned HALF_W = 16;

  localparam logic [OP_W-1:0] OP_EQ        = 5'd0;
  localparam logic [OP_W-1:0] OP_NE        = 5'd1;
  localparam logic [OP_W-1:0] OP_LT        = 5'd2;
  localparam logic [OP_W-1:0] OP_LE        = 5'd3;
  localparam logic [OP_W-1:0] OP_GT        = 5'd4;
  localparam logic [OP_W-1:0] OP_GE        = 5'd5;
  localparam logic [OP_W-1:0] OP_ISNAN     = 5'd6;
  localparam logic [OP_W-1:0] OP_ISINF     = 5'd7;
  localparam logic [OP_W-1:0] OP_ISFINITE  = 5'd8;
  localparam logic [OP_W-1:0] OP_SIGNBIT   = 5'd9;
  localparam logic [OP_W-1:0] OP_NONZERO   = 5'd10;
  localparam logic [OP_W-1:0] OP_COPYSIGN  = 5'd11;
  localparam logic [OP_W-1:0] OP_NEXTAFTER = 5'd12;
  localparam logic [OP_W-1:0] OP_SPACING   = 5'd13;
  localparam logic [OP_W-1:0] OP_EQ_NONAN  = 5'd14;
  localparam logic [OP_W-1:0] OP_LT_NONAN  = 5'd15;
  localparam logic [OP_W-1:0] OP_LE_NONAN  = 5'd16;

  localparam logic [HALF_W-1:0] EXP_MASK    = 16'h7c00;
  localparam logic [HALF_W-1:0] MAN_MASK    = 16'h03ff;
  localparam logic [HALF_W-1:0] MAX_FINITE  = 16'h7bff;
  localparam logic [HALF_W-1:0] SPC_NEG_OFS = 16'h2c00;
  localparam logic [HALF_W-1:0] SPC_POS_OFS = 16'h2800;
  localparam logic [HALF_W-1:0] EXP_ONE     = 16'h0400;
  localparam logic [HALF_W-1:0] SIGN_MASK   = 16'h8000;
  localparam logic [HALF_W-1:0] MAG_MASK    = 16'h7fff;
  localparam logic [HALF_W-1:0] QNAN_BITS   = 16'h7e00;

  typedef struct packed {
    logic [HALF_W-1:0] word;
    logic              invalid;
    logic              overflow;
  } hfcc_result_t;

  function automatic logic is_nan16(input logic [HALF_W-1:0] h);
    return ((h & EXP_MASK) == EXP_MASK) && ((h & MAN_MASK) != '0);
  endfunction

  function automatic logic is_inf16(input logic [HALF_W-1:0] h);
    return ((h & EXP_MASK) == EXP_MASK) && ((h & MAN_MASK) == '0);
  endfunction

  function automatic logic is_fin16(input logic [HALF_W-1:0] h);
    return (h & EXP_MASK) != EXP_MASK;
  endfunction

  // signed zeros compare equal
  function automatic logic eq_raw(input logic [HALF_W-1:0] a, input logic [HALF_W-1:0] b);
    return (a == b) || (((a | b) & MAG_MASK) == '0);
  endfunction

  function automatic logic lt_raw(input logic [HALF_W-1:0] a, input logic [HALF_W-1:0] b);
    logic r;
    if (a[HALF_W-1]) begin
      if (b[HALF_W-1]) r = (a & MAG_MASK) > (b & MAG_MASK);
      else r = (a != SIGN_MASK) || (b != '0);
    end else if (b[HALF_W-1]) begin
      r = 1'b0;
    end else begin
      r = (a & MAG_MASK) < (b & MAG_MASK);
    end
    return r;
  endfunction

  function automatic logic le_raw(input logic [HALF_W-1:0] a, input logic [HALF_W-1:0] b);
    logic r;
    if (a[HALF_W-1]) begin
      if (b[HALF_W-1]) r = (a & MAG_MASK) >= (b & MAG_MASK);
      else r = 1'b1;
    end else if (b[HALF_W-1]) begin
      r = (a == '0) && (b == SIGN_MASK);
    end else begin
      r = (a & MAG_MASK) <= (b & MAG_MASK);
    end
    return r;
  endfunction

endpackage

// ===== sv/half_float_compare_classify_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_float_compare_classify_unit
// Binary16 compare / classify / copysign / nextafter / spacing unit with an
// input register and a result register around one combinational pass.
// ----------------------------------------------------------------------------
//  channel  handshake              word
//  in       in_valid / in_ready    opcode, operand_a, operand_b
//  out      out_valid / out_ready  result_word, invalid_flag, overflow_flag
//
//  a word accepted into the input register passes hfcc_core and is captured
//  in the result register; one word per cycle sustained while out_ready is
//  high, set by the single pass through hfcc_core between two registers
//  rst clears both stage valid bits; payload registers are not reset
//  a stalled result holds the output register; the input register keeps
//  filling until both stages are full, then in_ready drops
// ----------------------------------------------------------------------------
module half_float_compare_classify_unit import hfcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   opcode,
  input  logic [HALF_W-1:0] operand_a,
  input  logic [HALF_W-1:0] operand_b,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HALF_W-1:0] result_word,
  output logic              invalid_flag,
  output logic              overflow_flag
);

  logic              s1_valid;
  logic [OP_W-1:0]   s1_op;
  logic [HALF_W-1:0] s1_a;
  logic [HALF_W-1:0] s1_b;
  hfcc_result_t      core_res;
  hfcc_result_t      s2_res;
  logic              s2_load;

  assign s2_load  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_op <= opcode;
      s1_a  <= operand_a;
      s1_b  <= operand_b;
    end
  end

  hfcc_core u_core (
    .opcode    (s1_op),
    .operand_a (s1_a),
    .operand_b (s1_b),
    .result    (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
    if (s2_load && s1_valid) begin
      s2_res <= core_res;
    end
  end

  assign result_word   = s2_res.word;
  assign invalid_flag  = s2_res.invalid;
  assign overflow_flag = s2_res.overflow;

  // overflow only from nextafter, and then the word is an infinity
  a_ovf_src: assert property (@(posedge clk) disable iff (rst)
    s1_valid && core_res.overflow |-> s1_op == OP_NEXTAFTER &&
      (core_res.word & MAG_MASK) == EXP_MASK)
    else $error("overflow flag without nextafter infinity");

  a_inv_nan: assert property (@(posedge clk) disable iff (rst)
    s1_valid && core_res.invalid |-> core_res.word == QNAN_BITS &&
      (s1_op == OP_NEXTAFTER || s1_op == OP_SPACING))
    else $error("invalid flag without quiet nan result");

  a_adv: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_load |=> out_valid)
    else $error("stage 1 word lost on advance");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_load |=> s1_valid && $stable(s1_a) && $stable(s1_op))
    else $error("stage 1 word changed while stalled");

endmodule

// ===== sv/hfcc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfcc_core
// Single-pass combinational datapath: compares, classification, copysign,
// nextafter and spacing on raw binary16 words.
// ----------------------------------------------------------------------------
module hfcc_core import hfcc_pkg::*; (
  input  logic [OP_W-1:0]   opcode,
  input  logic [HALF_W-1:0] operand_a,
  input  logic [HALF_W-1:0] operand_b,
  output hfcc_result_t      result
);

  logic              both_num;
  logic [4:0]        exp_a;
  logic [HALF_W-1:0] e_full;
  logic [HALF_W-1:0] spc_word;
  logic              spc_inv;
  logic [HALF_W-1:0] nxt_word;
  logic              nxt_inv;
  logic              toward_zero;

  assign both_num = !is_nan16(operand_a) && !is_nan16(operand_b);
  assign exp_a    = operand_a[14:10];
  assign e_full   = operand_a & EXP_MASK;

  // spacing: gap to the next value toward +infinity, always positive
  always_comb begin
    spc_inv  = 1'b0;
    spc_word = 16'd1;
    if (e_full == EXP_MASK || operand_a == MAX_FINITE) begin
      spc_inv  = 1'b1;
      spc_word = QNAN_BITS;
    end else if (operand_a[15] && (operand_a & MAN_MASK) == '0) begin
      if (e_full > SPC_NEG_OFS) spc_word = e_full - SPC_NEG_OFS;
      else if (e_full > EXP_ONE) spc_word = 16'd1 << (exp_a - 5'd2);
    end else begin
      if (e_full > SPC_POS_OFS) spc_word = e_full - SPC_POS_OFS;
      else if (e_full > EXP_ONE) spc_word = 16'd1 << (exp_a - 5'd1);
    end
  end

  // nextafter: step the raw word by one toward operand_b
  always_comb begin
    nxt_inv     = 1'b0;
    toward_zero = !operand_b[15] || ((operand_a & MAG_MASK) > (operand_b & MAG_MASK));
    if (!is_fin16(operand_a) || is_nan16(operand_b)) begin
      nxt_inv  = 1'b1;
      nxt_word = QNAN_BITS;
    end else if (eq_raw(operand_a, operand_b)) begin
      nxt_word = operand_a;
    end else if ((operand_a & MAG_MASK) == '0) begin
      nxt_word = (operand_b & SIGN_MASK) + 16'd1;
    end else if (!operand_a[15]) begin
      nxt_word = ($signed(operand_a) > $signed(operand_b)) ? operand_a - 16'd1
                                                         : operand_a + 16'd1;
    end else begin
      nxt_word = toward_zero ? operand_a - 16'd1 : operand_a + 16'd1;
    end
  end

  always_comb begin
    result = '0;
    unique case (opcode)
      OP_EQ:        result.word[0] = both_num && eq_raw(operand_a, operand_b);
      OP_NE:        result.word[0] = !(both_num && eq_raw(operand_a, operand_b));
      OP_LT:        result.word[0] = both_num && lt_raw(operand_a, operand_b);
      OP_LE:        result.word[0] = both_num && le_raw(operand_a, operand_b);
      OP_GT:        result.word[0] = both_num && lt_raw(operand_b, operand_a);
      OP_GE:        result.word[0] = both_num && le_raw(operand_b, operand_a);
      OP_ISNAN:     result.word[0] = is_nan16(operand_a);
      OP_ISINF:     result.word[0] = is_inf16(operand_a);
      OP_ISFINITE:  result.word[0] = is_fin16(operand_a);
      OP_SIGNBIT:   result.word[0] = operand_a[15];
      OP_NONZERO:   result.word[0] = (operand_a & MAG_MASK) != '0;
      OP_COPYSIGN:  result.word    = (operand_a & MAG_MASK) | (operand_b & SIGN_MASK);
      OP_NEXTAFTER: begin
        result.word     = nxt_word;
        result.invalid  = nxt_inv;
        result.overflow = is_inf16(nxt_word);
      end
      OP_SPACING: begin
        result.word    = spc_word;
        result.invalid = spc_inv;
      end
      OP_EQ_NONAN:  result.word[0] = eq_raw(operand_a, operand_b);
      OP_LT_NONAN:  result.word[0] = lt_raw(operand_a, operand_b);
      OP_LE_NONAN:  result.word[0] = le_raw(operand_a, operand_b);
      default:      result = '0;
    endcase
  end

endmodule
